>>> sv/sas_pkg.sv
// Shared types, codes and constants for the sprite animation sequencer.
package sas_pkg;

  localparam int MAX_ANIMS_DEF = 8;

  // Shared divider operand widths
  localparam int DIVIDEND_W = 19;
  localparam int DIVISOR_W  = 16;

  localparam logic [11:0] ATLAS_COLS_RST   = 12'd1;
  localparam logic [9:0]  FRAME_WIDTH_RST  = 10'd16;
  localparam logic [9:0]  FRAME_HEIGHT_RST = 10'd16;

  // Config register index, taken from paddr[3:2]
  localparam logic [1:0] CFG_IDX_COLS   = 2'd0;
  localparam logic [1:0] CFG_IDX_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IDX_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_PLAY   = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_APPEND = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    DIV_SRC_TICK,
    DIV_SRC_WRAP,
    DIV_SRC_COLS
  } div_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_CHK,
    ST_DIV_T,
    ST_STEP,
    ST_DIV_W,
    ST_WRAP,
    ST_END,
    ST_FLAT,
    ST_DIV_C,
    ST_MUL,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [11:0] start;
    logic [11:0] count;
    logic [11:0] idle;
    logic [15:0] dur;
    logic        loop_en;
  } anim_entry_t;

  typedef struct packed {
    logic     accept;
    logic     rd;
    logic     div_start;
    div_src_t div_src;
    logic     step;
    logic     wrap;
    logic     fin;
    logic     mul;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic loop_en;
    logic n_ge_k;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/sas_div.sv
// Restoring divider, one quotient bit per cycle.
module sas_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [sas_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [sas_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [sas_pkg::DIVIDEND_W-1:0] quotient,
  output logic [sas_pkg::DIVISOR_W-1:0]  remainder
);

  localparam int NW    = sas_pkg::DIVIDEND_W;
  localparam int DW    = sas_pkg::DIVISOR_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    dsr_r, dsr_nxt;
  logic [DW:0]      trial;
  logic [DW:0]      diff;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NW);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> sv/sas_datapath.sv
// Datapath: animation table, playback state, config registers, divider and result register.
module sas_datapath #(
  parameter int MAX_ANIMS = sas_pkg::MAX_ANIMS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sas_pkg::ctrl_cmd_t  cmd,
  output sas_pkg::dp_status_t status,
  input  logic [1:0]          in_req_type,
  input  logic [2:0]          in_anim_select,
  input  logic [15:0]         in_time_delta,
  input  logic [11:0]         in_def_start_frame,
  input  logic [11:0]         in_def_frame_count,
  input  logic [11:0]         in_def_idle_frame,
  input  logic [15:0]         in_def_frame_duration,
  input  logic                in_def_loop,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_append_ok,
  output logic [2:0]          out_appended_index,
  output logic                out_frame_visible,
  output logic [12:0]         out_atlas_frame,
  output logic [21:0]         out_source_x,
  output logic [22:0]         out_source_y,
  output logic                out_is_playing,
  output logic [2:0]          out_active_anim
);

  localparam int TW = $clog2(MAX_ANIMS + 1);
  localparam int IW = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
  localparam int CW = TW + 3;
  localparam int NW = sas_pkg::DIVIDEND_W;
  localparam int DW = sas_pkg::DIVISOR_W;

  // Config registers
  logic [11:0] cols_r;
  logic [9:0]  fw_r;
  logic [9:0]  fh_r;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= sas_pkg::ATLAS_COLS_RST;
      fw_r   <= sas_pkg::FRAME_WIDTH_RST;
      fh_r   <= sas_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sas_pkg::CFG_IDX_COLS:   cols_r <= pwdata[11:0];
        sas_pkg::CFG_IDX_WIDTH:  fw_r   <= pwdata[9:0];
        sas_pkg::CFG_IDX_HEIGHT: fh_r   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sas_pkg::CFG_IDX_COLS:   prdata = {20'd0, cols_r};
      sas_pkg::CFG_IDX_WIDTH:  prdata = {22'd0, fw_r};
      sas_pkg::CFG_IDX_HEIGHT: prdata = {22'd0, fh_r};
      default:                 prdata = '0;
    endcase
  end

  // Animation table
  sas_pkg::anim_entry_t mem [MAX_ANIMS];
  sas_pkg::anim_entry_t ent_r;
  sas_pkg::anim_entry_t new_ent;

  // Playback state
  logic [TW-1:0]  total_r;
  logic [2:0]     cur_r;
  logic [11:0]    offset_r;
  logic [16:0]    elapsed_r;
  logic           playing_r;

  // Latched request and working registers
  sas_pkg::req_t  req_r;
  logic [15:0]    dt_r;
  logic           ok_r;
  logic [2:0]     aidx_r;
  logic [17:0]    sum_r;
  logic [27:0]    prod_r;
  logic [12:0]    flat_r;
  logic [21:0]    sx_r;
  logic [22:0]    sy_r;

  logic           out_valid_r;
  logic           ok_o_r;
  logic [2:0]     aidx_o_r;
  logic           vis_o_r;
  logic [12:0]    flat_o_r;
  logic [21:0]    sx_o_r;
  logic [22:0]    sy_o_r;
  logic           playing_o_r;
  logic [2:0]     cur_o_r;

  sas_pkg::req_t  req_in;
  logic           tbl_full;
  logic           play_ok;
  logic           append_go;
  logic [IW-1:0]  rd_addr;
  logic [IW-1:0]  wr_addr;
  logic [15:0]    dur_eff;
  logic [11:0]    cols_eff;
  logic [17:0]    sum_c;
  logic [11:0]    k_c;
  logic [12:0]    flat_c;
  logic [17:0]    end_diff;
  logic [21:0]    sx_c;
  logic [22:0]    sy_c;
  logic [NW-1:0]  div_a;
  logic [DW-1:0]  div_b;
  logic           div_done;
  logic [NW-1:0]  div_q;
  logic [DW-1:0]  div_rem;
  logic           vis_c;

  assign req_in    = sas_pkg::req_t'(in_req_type);
  assign tbl_full  = (total_r == TW'(MAX_ANIMS));
  assign play_ok   = (CW'(in_anim_select) < CW'(total_r))
                     && !((in_anim_select == cur_r) && playing_r);
  assign append_go = cmd.accept && (req_in == sas_pkg::REQ_APPEND) && !tbl_full;
  assign rd_addr   = IW'(cur_r);
  assign wr_addr   = IW'(total_r);

  assign new_ent.start   = in_def_start_frame;
  assign new_ent.count   = in_def_frame_count;
  assign new_ent.idle    = in_def_idle_frame;
  assign new_ent.dur     = in_def_frame_duration;
  assign new_ent.loop_en = in_def_loop;

  always_ff @(posedge clk) begin
    if (append_go) begin
      mem[wr_addr] <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      ent_r <= mem[rd_addr];
    end
  end

  assign dur_eff  = (ent_r.dur == 16'd0) ? 16'd1 : ent_r.dur;
  assign cols_eff = (cols_r == 12'd0) ? 12'd1 : cols_r;
  assign sum_c    = {1'b0, elapsed_r} + {2'd0, dt_r};
  // Frames from the current one to the last, both included
  assign k_c      = (offset_r < ent_r.count) ? (ent_r.count - offset_r) : 12'd1;
  assign flat_c   = {1'b0, ent_r.start} + {1'b0, (playing_r ? offset_r : ent_r.idle)};
  assign end_diff = sum_r - prod_r[17:0];
  assign sx_c     = div_rem[11:0] * fw_r;
  assign sy_c     = div_q[12:0] * fh_r;
  assign vis_c    = (total_r != '0);

  always_comb begin
    unique case (cmd.div_src)
      sas_pkg::DIV_SRC_TICK: begin
        div_a = {1'b0, sum_c};
        div_b = dur_eff;
      end
      sas_pkg::DIV_SRC_WRAP: begin
        div_a = div_q + {7'd0, offset_r};
        div_b = {4'd0, ent_r.count};
      end
      sas_pkg::DIV_SRC_COLS: begin
        div_a = {6'd0, flat_c};
        div_b = {4'd0, cols_eff};
      end
      default: begin
        div_a = '0;
        div_b = '0;
      end
    endcase
  end

  sas_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  // Playback state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      cur_r     <= '0;
      offset_r  <= '0;
      elapsed_r <= '0;
      playing_r <= 1'b0;
    end else if (cmd.accept) begin
      unique case (req_in)
        sas_pkg::REQ_TICK: ;
        sas_pkg::REQ_PLAY: begin
          if (play_ok) begin
            cur_r     <= in_anim_select;
            offset_r  <= '0;
            elapsed_r <= '0;
            playing_r <= 1'b1;
          end
        end
        sas_pkg::REQ_STOP: playing_r <= 1'b0;
        sas_pkg::REQ_APPEND: begin
          if (!tbl_full) begin
            total_r <= total_r + TW'(1);
          end
        end
        default: ;
      endcase
    end else if (cmd.step) begin
      if (ent_r.loop_en) begin
        elapsed_r <= {1'b0, div_rem};
      end else if (!status.n_ge_k) begin
        elapsed_r <= {1'b0, div_rem};
        offset_r  <= offset_r + div_q[11:0];
      end
    end else if (cmd.wrap) begin
      offset_r <= div_rem[11:0];
    end else if (cmd.fin) begin
      elapsed_r <= end_diff[16:0];
      offset_r  <= ent_r.count - 12'd1;
      playing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= req_in;
      dt_r   <= in_time_delta;
      ok_r   <= append_go;
      aidx_r <= append_go ? 3'(total_r) : 3'd0;
    end
    if (cmd.div_start && (cmd.div_src == sas_pkg::DIV_SRC_TICK)) begin
      sum_r <= sum_c;
    end
    if (cmd.div_start && (cmd.div_src == sas_pkg::DIV_SRC_COLS)) begin
      flat_r <= flat_c;
    end
    if (cmd.step) begin
      prod_r <= k_c * dur_eff;
    end
    if (cmd.mul) begin
      sx_r <= sx_c;
      sy_r <= sy_c;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ok_o_r      <= ok_r;
      aidx_o_r    <= aidx_r;
      vis_o_r     <= vis_c;
      flat_o_r    <= vis_c ? flat_r : 13'd0;
      sx_o_r      <= vis_c ? sx_r : 22'd0;
      sy_o_r      <= vis_c ? sy_r : 23'd0;
      playing_o_r <= playing_r;
      cur_o_r     <= cur_r;
    end
  end

  assign status.tick_go  = (req_r == sas_pkg::REQ_TICK) && playing_r && vis_c
                           && (ent_r.count > 12'd1);
  assign status.loop_en  = ent_r.loop_en;
  assign status.n_ge_k   = (div_q >= {7'd0, k_c});
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_append_ok      = ok_o_r;
  assign out_appended_index = aidx_o_r;
  assign out_frame_visible  = vis_o_r;
  assign out_atlas_frame    = flat_o_r;
  assign out_source_x       = sx_o_r;
  assign out_source_y       = sy_o_r;
  assign out_is_playing     = playing_o_r;
  assign out_active_anim    = cur_o_r;

endmodule

>>> sv/sas_ctrl.sv
// Controller state machine sequencing one transaction through the datapath.
module sas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sas_pkg::dp_status_t status,
  output sas_pkg::ctrl_cmd_t  cmd
);

  sas_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sas_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sas_pkg::ST_IDLE:  if (in_valid) state_nxt = sas_pkg::ST_RD;
      sas_pkg::ST_RD:    state_nxt = sas_pkg::ST_CHK;
      sas_pkg::ST_CHK:   state_nxt = status.tick_go ? sas_pkg::ST_DIV_T : sas_pkg::ST_FLAT;
      sas_pkg::ST_DIV_T: if (status.div_done) state_nxt = sas_pkg::ST_STEP;
      sas_pkg::ST_STEP: begin
        priority if (status.loop_en) state_nxt = sas_pkg::ST_DIV_W;
        else if (status.n_ge_k)      state_nxt = sas_pkg::ST_END;
        else                         state_nxt = sas_pkg::ST_FLAT;
      end
      sas_pkg::ST_DIV_W: if (status.div_done) state_nxt = sas_pkg::ST_WRAP;
      sas_pkg::ST_WRAP:  state_nxt = sas_pkg::ST_FLAT;
      sas_pkg::ST_END:   state_nxt = sas_pkg::ST_FLAT;
      sas_pkg::ST_FLAT:  state_nxt = sas_pkg::ST_DIV_C;
      sas_pkg::ST_DIV_C: if (status.div_done) state_nxt = sas_pkg::ST_MUL;
      sas_pkg::ST_MUL:   state_nxt = sas_pkg::ST_DONE;
      sas_pkg::ST_DONE:  if (status.out_free) state_nxt = sas_pkg::ST_IDLE;
      default:           state_nxt = sas_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.div_src  = sas_pkg::DIV_SRC_TICK;
    unique case (state_r)
      sas_pkg::ST_IDLE: cmd.accept = in_valid;
      sas_pkg::ST_RD:   cmd.rd = 1'b1;
      sas_pkg::ST_CHK: begin
        cmd.div_start = status.tick_go;
        cmd.div_src   = sas_pkg::DIV_SRC_TICK;
      end
      sas_pkg::ST_STEP: begin
        cmd.step      = 1'b1;
        cmd.div_start = status.loop_en;
        cmd.div_src   = sas_pkg::DIV_SRC_WRAP;
      end
      sas_pkg::ST_WRAP: cmd.wrap = 1'b1;
      sas_pkg::ST_END:  cmd.fin = 1'b1;
      sas_pkg::ST_FLAT: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = sas_pkg::DIV_SRC_COLS;
      end
      sas_pkg::ST_MUL:  cmd.mul = 1'b1;
      sas_pkg::ST_DONE: cmd.load_out = status.out_free;
      default: ;
    endcase
  end

  assign in_stall = (state_r != sas_pkg::ST_IDLE);

endmodule

>>> sv/sprite_animation_sequencer_core.sv
// Top level: sprite animation sequencer, one transaction in flight at a time.
// Play, stop, append and idle ticks make one division, a non-looping tick two and a looping
// tick three, all on the shared one-bit-per-cycle divider. A waiting result does not block
// the next accept. Reset (rst_n, synchronous) empties the table and stops playback.
module sprite_animation_sequencer_core #(
  parameter int MAX_ANIMS = sas_pkg::MAX_ANIMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [2:0]  in_anim_select,
  input  logic [15:0] in_time_delta,
  input  logic [11:0] in_def_start_frame,
  input  logic [11:0] in_def_frame_count,
  input  logic [11:0] in_def_idle_frame,
  input  logic [15:0] in_def_frame_duration,
  input  logic        in_def_loop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_append_ok,
  output logic [2:0]  out_appended_index,
  output logic        out_frame_visible,
  output logic [12:0] out_atlas_frame,
  output logic [21:0] out_source_x,
  output logic [22:0] out_source_y,
  output logic        out_is_playing,
  output logic [2:0]  out_active_anim,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sas_pkg::ctrl_cmd_t  cmd;
  sas_pkg::dp_status_t status;

  assign pready = 1'b1;

  sas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sas_datapath #(
    .MAX_ANIMS (MAX_ANIMS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .in_req_type           (in_req_type),
    .in_anim_select        (in_anim_select),
    .in_time_delta         (in_time_delta),
    .in_def_start_frame    (in_def_start_frame),
    .in_def_frame_count    (in_def_frame_count),
    .in_def_idle_frame     (in_def_idle_frame),
    .in_def_frame_duration (in_def_frame_duration),
    .in_def_loop           (in_def_loop),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_append_ok         (out_append_ok),
    .out_appended_index    (out_appended_index),
    .out_frame_visible     (out_frame_visible),
    .out_atlas_frame       (out_atlas_frame),
    .out_source_x          (out_source_x),
    .out_source_y          (out_source_y),
    .out_is_playing        (out_is_playing),
    .out_active_anim       (out_active_anim)
  );

endmodule
